FILE: src/color_sequence_symbol_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the color sequence symbol decoder
// Shared property forms, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COLOR_SEQUENCE_SYMBOL_DECODER_UNIT_DEFINES_SVH
`define COLOR_SEQUENCE_SYMBOL_DECODER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSSD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cssd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CSSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cssd assertion failed");

`endif

FILE: src/cssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssd_pkg
// Types, codes and constants of the color sequence symbol decoder.
// ----------------------------------------------------------------------------
package cssd_pkg;

    localparam int CHAN_W    = 8;
    localparam int NUM_CODES = 8;
    localparam int CODE_W    = 3;
    localparam int CFG_IDX_W = 4;
    localparam int SQ_W      = 2 * CHAN_W;
    localparam int DIST_W    = SQ_W + 2;

    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [CODE_W-1:0]    code_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Packed as blue in bits 7:0, green 15:8, red 23:16.
    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } color_t;

    localparam int COLOR_W = $bits(color_t);

    typedef color_t [NUM_CODES-1:0] palette_t;

    localparam code_t CODE_PLUS       = 3'd0;
    localparam code_t CODE_MINUS      = 3'd1;
    localparam code_t CODE_LEFT       = 3'd2;
    localparam code_t CODE_RIGHT      = 3'd3;
    localparam code_t CODE_LOOP_OPEN  = 3'd4;
    localparam code_t CODE_LOOP_CLOSE = 3'd5;
    localparam code_t CODE_EMIT       = 3'd6;
    localparam code_t CODE_ACCEPT     = 3'd7;

    // Palette search follows ASCII order of the characters: + , - . < > [ ]
    localparam code_t SEARCH_ORDER [NUM_CODES] = '{
        CODE_PLUS, CODE_ACCEPT, CODE_MINUS, CODE_EMIT,
        CODE_LEFT, CODE_RIGHT, CODE_LOOP_OPEN, CODE_LOOP_CLOSE
    };

    localparam logic [DIST_W-1:0] SIMILAR_LIMIT = DIST_W'(500);

    localparam color_t YELLOW = '{red: 8'hFF, green: 8'hFF, blue: 8'h00};

endpackage

FILE: src/cssd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssd channel interfaces
// Valid/ready channels for the input color word and the symbol word.
// ----------------------------------------------------------------------------
interface cssd_pixel_if;
    logic            valid;
    logic            ready;
    cssd_pkg::chan_t blue;
    cssd_pkg::chan_t green;
    cssd_pkg::chan_t red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface cssd_symbol_if;
    logic            valid;
    logic            ready;
    cssd_pkg::code_t symbol_code;

    modport source (output valid, output symbol_code, input ready);
    modport sink   (input valid, input symbol_code, output ready);
endinterface

FILE: src/cssd_similar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssd_similar
// Sum of squared channel differences of two colors, compared with the limit.
// ----------------------------------------------------------------------------
module cssd_similar (
    input  cssd_pkg::color_t a,
    input  cssd_pkg::color_t b,
    output logic             similar
);
    import cssd_pkg::*;

    chan_t             d_blue;
    chan_t             d_green;
    chan_t             d_red;
    logic [SQ_W-1:0]   sq_blue;
    logic [SQ_W-1:0]   sq_green;
    logic [SQ_W-1:0]   sq_red;
    logic [DIST_W-1:0] sq_sum;

    assign d_blue  = (a.blue  > b.blue)  ? a.blue  - b.blue  : b.blue  - a.blue;
    assign d_green = (a.green > b.green) ? a.green - b.green : b.green - a.green;
    assign d_red   = (a.red   > b.red)   ? a.red   - b.red   : b.red   - a.red;

    assign sq_blue  = SQ_W'(d_blue)  * SQ_W'(d_blue);
    assign sq_green = SQ_W'(d_green) * SQ_W'(d_green);
    assign sq_red   = SQ_W'(d_red)   * SQ_W'(d_red);

    assign sq_sum  = DIST_W'(sq_blue) + DIST_W'(sq_green) + DIST_W'(sq_red);
    assign similar = (sq_sum < SIMILAR_LIMIT);

endmodule

FILE: src/cssd_palette_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssd_palette_match
// Compares a color with all eight palette entries and picks the first hit.
// ----------------------------------------------------------------------------
module cssd_palette_match (
    input  cssd_pkg::color_t   color,
    input  cssd_pkg::palette_t palette,
    output logic               hit,
    output cssd_pkg::code_t    code
);
    import cssd_pkg::*;

    logic [NUM_CODES-1:0] entry_similar;

    for (genvar i = 0; i < NUM_CODES; i++)
    begin : g_entry
        cssd_similar u_similar (
            .a       (color),
            .b       (palette[i]),
            .similar (entry_similar[i])
        );
    end

    // Walk the search order backwards so the earliest match is written last.
    always_comb
    begin
        hit  = 1'b0;
        code = CODE_PLUS;
        for (int k = NUM_CODES - 1; k >= 0; k--)
        begin
            if (entry_similar[SEARCH_ORDER[k]])
            begin
                hit  = 1'b1;
                code = SEARCH_ORDER[k];
            end
        end
    end

endmodule

FILE: src/color_sequence_symbol_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_sequence_symbol_decoder_unit
// Decodes a sequence of frame colors into instruction symbol codes.
// ----------------------------------------------------------------------------
// Takes one color word per cycle as long as the symbol side keeps ready high,
// and gives at most one symbol word for each. A color word taken into the
// input register is decoded, once the output register can advance, by a
// single pass through ten distance units (eight palette entries, yellow and
// the separator), and its symbol word, if any, is presented from the output
// register. A stalled symbol word is held in the output register while one
// more color word can be taken into the input register.
// Palette registers are written through cfg_we/cfg_index/cfg_data; an index
// of eight or more is ignored. Write them only while no word is in flight.
module color_sequence_symbol_decoder_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  cssd_pkg::cfg_idx_t  cfg_index,
    input  logic [23:0]         cfg_data,
    cssd_pixel_if.sink          pixel,
    cssd_symbol_if.source       symbol
);
    import cssd_pkg::*;

    palette_t palette_reg;
    color_t   color_reg;
    logic     color_valid_reg;
    color_t   separator_reg;
    logic     captured_reg;
    logic     awaiting_reg;
    logic     out_valid_reg;
    code_t    out_code_reg;

    logic     advance;
    logic     process;
    logic     yellow_similar;
    logic     separator_similar;
    logic     palette_hit;
    code_t    palette_code;
    logic     search;
    logic     emit;
    logic     captured_next;
    logic     awaiting_next;

    assign advance      = !out_valid_reg || symbol.ready;
    assign process      = advance && color_valid_reg;
    assign pixel.ready  = !color_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_reg <= '0;
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_CODES)))
        begin
            palette_reg[cfg_index[CODE_W-1:0]] <= color_t'(cfg_data);
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_valid_reg <= 1'b0;
        end
        else if (pixel.valid && pixel.ready)
        begin
            color_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            color_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel.valid && pixel.ready)
        begin
            color_reg <= '{red: pixel.red, green: pixel.green, blue: pixel.blue};
        end
    end

    cssd_similar u_yellow (
        .a       (color_reg),
        .b       (YELLOW),
        .similar (yellow_similar)
    );

    cssd_similar u_separator (
        .a       (color_reg),
        .b       (separator_reg),
        .similar (separator_similar)
    );

    cssd_palette_match u_match (
        .color   (color_reg),
        .palette (palette_reg),
        .hit     (palette_hit),
        .code    (palette_code)
    );

    // Before capture, a non-yellow color becomes the separator and is searched
    // at once; yellow is skipped and leaves the capture flags unchanged.
    always_comb
    begin
        captured_next = captured_reg;
        awaiting_next = awaiting_reg;
        search        = 1'b0;
        if (!captured_reg)
        begin
            if (!yellow_similar)
            begin
                captured_next = 1'b1;
                search        = 1'b1;
            end
        end
        else if (awaiting_reg)
        begin
            search = 1'b1;
        end
        else if (separator_similar)
        begin
            awaiting_next = 1'b1;
        end
        if (search)
        begin
            awaiting_next = !palette_hit;
        end
        emit = search && palette_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            captured_reg  <= 1'b0;
            awaiting_reg  <= 1'b0;
            separator_reg <= '0;
        end
        else if (process)
        begin
            captured_reg <= captured_next;
            awaiting_reg <= awaiting_next;
            if (!captured_reg)
            begin
                separator_reg <= color_reg;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= process && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && emit)
        begin
            out_code_reg <= palette_code;
        end
    end

    assign symbol.valid       = out_valid_reg;
    assign symbol.symbol_code = out_code_reg;

endmodule

FILE: src/cssd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssd_checker
// Port-level checks of the symbol decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "color_sequence_symbol_decoder_unit_defines.svh"

module cssd_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            pixel_valid,
    input logic            pixel_ready,
    input logic            symbol_valid,
    input logic            symbol_ready,
    input cssd_pkg::code_t symbol_code
);
    import cssd_pkg::*;

    // A stalled symbol word stays put.
    `CSSD_ASSERT_NEXT(a_symbol_held, symbol_valid && !symbol_ready, symbol_valid)
    `CSSD_ASSERT_NEXT(a_code_held, symbol_valid && !symbol_ready, $stable(symbol_code))

    // A fresh symbol word comes from a color word taken through the input register.
    `CSSD_ASSERT_SAME(a_symbol_has_source, $rose(symbol_valid),
                      $past(pixel_valid && pixel_ready, 2))

    // With the symbol side ready, the decoder never pushes back.
    `CSSD_ASSERT_SAME(a_full_rate, symbol_ready, pixel_ready)

endmodule

bind color_sequence_symbol_decoder_unit cssd_checker u_cssd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel.valid),
    .pixel_ready  (pixel.ready),
    .symbol_valid (symbol.valid),
    .symbol_ready (symbol.ready),
    .symbol_code  (symbol.symbol_code)
);

FILE: tb/sv/color_sequence_symbol_decoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_sequence_symbol_decoder_unit_test
// Drives frame colors into the decoder under random idling on both sides,
// predicts the symbol words from its own model of the separator and palette
// state, and checks every symbol word in order. A directed part covers yellow
// skipping, the capture step, every code, priority among similar palette
// entries and the unmatched case; random phases run under several palettes.
// ----------------------------------------------------------------------------
module color_sequence_symbol_decoder_unit_test;

    import cssd_pkg::*;

    localparam int SIMILAR_BOUND  = 500;
    localparam int DRAIN_CYCLES   = 6;
    localparam int HOLD_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam color_t YELLOW_COLOR = 24'hFFFF00;
    localparam color_t BLACK        = 24'h000000;
    localparam color_t WHITE        = 24'hFFFFFF;

    localparam cfg_idx_t REG_COLOR_MINUS  = 4'd1;
    localparam cfg_idx_t REG_COLOR_EMIT   = 4'd6;
    localparam cfg_idx_t REG_COLOR_ACCEPT = 4'd7;
    localparam cfg_idx_t FIRST_UNUSED_REG = 4'd8;

    // Palette search order: ASCII order of + , - . < > [ ]
    localparam code_t ASCII_ORDER [NUM_CODES] = '{
        CODE_PLUS, CODE_ACCEPT, CODE_MINUS, CODE_EMIT,
        CODE_LEFT, CODE_RIGHT, CODE_LOOP_OPEN, CODE_LOOP_CLOSE
    };

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    logic [23:0] cfg_data;

    cssd_pixel_if  pixel_ch ();
    cssd_symbol_if symbol_ch ();

    color_sequence_symbol_decoder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_ch),
        .symbol    (symbol_ch)
    );

    // Decoder state as the testbench sees it.
    palette_t shadow_palette;
    color_t   sep_color;
    bit       sep_valid;
    bit       armed;
    code_t    expected_codes [$];

    int          mismatch_count = 0;
    int          stall_cycles   = 0;
    bit          idle_enable;
    int unsigned idle_pct;
    bit          hold_request;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic bit colors_close(color_t a, color_t b);
        int db;
        int dg;
        int dr;
        db = int'(a.blue) - int'(b.blue);
        dg = int'(a.green) - int'(b.green);
        dr = int'(a.red) - int'(b.red);
        return (db * db + dg * dg + dr * dr) < SIMILAR_BOUND;
    endfunction

    // Advances the decoder state by one color word and queues its symbol.
    function automatic void predict_color(color_t c);
        if (!sep_valid)
        begin
            if (colors_close(c, YELLOW_COLOR))
                return;
            sep_color = c;
            sep_valid = 1'b1;
            armed     = 1'b1;
        end
        if (armed)
        begin
            foreach (ASCII_ORDER[k])
            begin
                if (colors_close(c, shadow_palette[ASCII_ORDER[k]]))
                begin
                    expected_codes = {expected_codes, ASCII_ORDER[k]};
                    armed = 1'b0;
                    return;
                end
            end
            return;
        end
        if (colors_close(c, sep_color))
            armed = 1'b1;
    endfunction

    function automatic chan_t jitter_chan(chan_t v, int spread);
        int x;
        x = int'(v) + int'($urandom_range(0, 2 * spread)) - spread;
        if (x < 0)
            x = 0;
        if (x > 255)
            x = 255;
        return chan_t'(x);
    endfunction

    function automatic color_t jitter(color_t c, int spread);
        color_t r;
        r.blue  = jitter_chan(c.blue, spread);
        r.green = jitter_chan(c.green, spread);
        r.red   = jitter_chan(c.red, spread);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_symbol(input code_t got);
        code_t want;
        if (expected_codes.size() == 0)
            report_mismatch($sformatf("unexpected symbol word %0d", got));
        else
        begin
            want = expected_codes.pop_front();
            if (got !== want)
                report_mismatch($sformatf("symbol_code %0d, expected %0d", got, want));
        end
    endtask

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_color(input color_t c);
        int unsigned gap;
        if (idle_enable && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 5);
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.blue  <= c.blue;
        pixel_ch.green <= c.green;
        pixel_ch.red   <= c.red;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
        predict_color(c);
    endtask

    task automatic wait_idle();
        pixel_ch.valid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_idx_t index, input color_t value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        if (index < FIRST_UNUSED_REG)
            shadow_palette[index] = value;
    endtask

    // Writes all eight entries, then one index past the palette that must be dropped.
    task automatic load_palette(input palette_t p);
        for (int i = 0; i < NUM_CODES; i++)
            write_register(cfg_idx_t'(i), p[i]);
        write_register(FIRST_UNUSED_REG + cfg_idx_t'($urandom_range(0, 7)), color_t'($urandom()));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_items(input int count);
        int sent;
        int pick;
        int spread;
        sent = 0;
        while (sent < count)
        begin
            pick   = $urandom_range(0, 99);
            spread = ($urandom_range(0, 3) == 0) ? 16 : 6;
            if (pick < 70)
            begin
                // Separator followed by a symbol color, the normal frame sequence.
                send_color(jitter(sep_color, spread));
                send_color(jitter(shadow_palette[$urandom_range(0, NUM_CODES - 1)], spread));
                sent += 2;
            end
            else
            begin
                if (pick < 80)
                    send_color(color_t'($urandom()));
                else if (pick < 85)
                    send_color(jitter(YELLOW_COLOR, spread));
                else if (pick < 93)
                    send_color(jitter(shadow_palette[$urandom_range(0, NUM_CODES - 1)], spread));
                else
                    send_color(jitter(sep_color, spread));
                sent++;
            end
        end
    endtask

    task automatic run_phase(input palette_t p, input bit idle, input int unsigned pct,
                             input int count);
        wait_idle();
        load_palette(p);
        idle_enable <= idle;
        idle_pct    <= pct;
        send_random_items(count);
    endtask

    task automatic test_yellow_skip();
        send_color(YELLOW_COLOR);
        send_color(24'hFAF50A);
    endtask

    // The palette is still at reset, so every entry matches black; plus wins.
    task automatic test_capture_match();
        send_color(BLACK);
    endtask

    task automatic test_every_code();
        palette_t p;
        p[CODE_PLUS]       = 24'hFF0000;
        p[CODE_MINUS]      = 24'h00FF00;
        p[CODE_LEFT]       = 24'h0000FF;
        p[CODE_RIGHT]      = 24'h00FFFF;
        p[CODE_LOOP_OPEN]  = 24'hFF00FF;
        p[CODE_LOOP_CLOSE] = WHITE;
        p[CODE_EMIT]       = 24'h808080;
        p[CODE_ACCEPT]     = 24'h404040;
        wait_idle();
        load_palette(p);
        for (int i = 0; i < NUM_CODES; i++)
        begin
            send_color(BLACK);
            send_color(shadow_palette[i]);
        end
    endtask

    task automatic test_no_match();
        send_color(BLACK);
        send_color(24'h202020);
        send_color(24'hFA0505);
        send_color(24'hFF0000);
    endtask

    task automatic test_priority();
        wait_idle();
        write_register(REG_COLOR_MINUS, 24'h123459);
        write_register(REG_COLOR_EMIT, 24'h123456);
        cfg_we <= 1'b0;
        send_color(BLACK);
        send_color(24'h123457);
        wait_idle();
        write_register(REG_COLOR_ACCEPT, 24'h12345C);
        cfg_we <= 1'b0;
        send_color(BLACK);
        send_color(24'h123457);
    endtask

    // The symbol side holds off while color words keep coming.
    task automatic test_backpressure();
        idle_enable  <= 1'b0;
        hold_request <= 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            send_color(jitter(sep_color, 4));
            send_color(jitter(shadow_palette[$urandom_range(0, NUM_CODES - 1)], 4));
        end
        idle_enable <= 1'b1;
    endtask

    task automatic test_random_palette();
        palette_t p;
        for (int i = 0; i < NUM_CODES; i++)
            p[i] = color_t'($urandom());
        run_phase(p, 1'b1, 25, 180);
    endtask

    task automatic test_extreme_palettes();
        palette_t p;
        for (int i = 0; i < NUM_CODES; i++)
            p[i] = BLACK;
        run_phase(p, 1'b1, 10, 70);
        for (int i = 0; i < NUM_CODES; i++)
            p[i] = WHITE;
        run_phase(p, 1'b0, 0, 70);
    endtask

    // All entries near one color, so priority decides most matches.
    task automatic test_clustered_palette();
        palette_t p;
        color_t   base;
        base = color_t'($urandom());
        for (int i = 0; i < NUM_CODES; i++)
            p[i] = jitter(base, 12);
        run_phase(p, 1'b1, 35, 180);
    endtask

    task automatic test_final_no_idle();
        palette_t p;
        for (int i = 0; i < NUM_CODES; i++)
            p[i] = color_t'($urandom());
        run_phase(p, 1'b0, 0, 140);
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        pixel_ch.valid <= 1'b0;
        pixel_ch.blue  <= '0;
        pixel_ch.green <= '0;
        pixel_ch.red   <= '0;
        idle_enable    <= 1'b1;
        idle_pct       <= 20;
        hold_request   <= 1'b0;
        shadow_palette = '0;
        sep_color      = '0;
        sep_valid      = 1'b0;
        armed          = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_yellow_skip();
        test_capture_match();
        test_every_code();
        test_no_match();
        test_priority();
        test_backpressure();
        test_random_palette();
        test_extreme_palettes();
        test_clustered_palette();
        test_final_no_idle();

        wait_idle();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Symbol side: checks each word taken and drives ready with random stalls.
    initial
    begin : symbol_sink
        int burst;
        burst = 0;
        symbol_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && symbol_ch.valid && symbol_ch.ready)
                check_symbol(symbol_ch.symbol_code);
            if (hold_request)
            begin
                hold_request <= 1'b0;
                burst = HOLD_CYCLES;
            end
            if (burst > 0)
            begin
                symbol_ch.ready <= 1'b0;
                burst--;
            end
            else if (rst_n && idle_enable && $urandom_range(0, 99) < idle_pct)
            begin
                symbol_ch.ready <= 1'b0;
                burst = $urandom_range(0, 4);
            end
            else
                symbol_ch.ready <= rst_n;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pixel_ch.valid && pixel_ch.ready) ||
            (symbol_ch.valid && symbol_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule

FILE: sim.f
+incdir+src
src/cssd_pkg.sv
src/cssd_if.sv
src/cssd_similar.sv
src/cssd_palette_match.sv
src/color_sequence_symbol_decoder_unit.sv
src/cssd_checker.sv
tb/sv/color_sequence_symbol_decoder_unit_test.sv
